/* rtl/atrs_pkg.sv */
// ----------------------------------------------------------------------------
// atrs_pkg
// shared constants, command codes, sequencer states and control structs for
// the ant tour roulette step block
// ----------------------------------------------------------------------------
package atrs_pkg;

  localparam int MAX_CITIES  = 64;
  localparam int CITY_BITS   = $clog2(MAX_CITIES);
  localparam int COUNT_BITS  = CITY_BITS + 1;
  localparam int WEIGHT_BITS = 32;
  localparam int RANDOM_BITS = 16;
  localparam int CMD_BITS    = 2;

  // row sum of MAX_CITIES weights stays below 2^(WEIGHT_BITS+CITY_BITS)
  localparam int SUM_BITS    = WEIGHT_BITS + CITY_BITS;
  localparam int PROD_BITS   = SUM_BITS + RANDOM_BITS;
  localparam int ADDR_BITS   = 2 * CITY_BITS;
  localparam int TABLE_DEPTH = MAX_CITIES * MAX_CITIES;

  localparam logic [COUNT_BITS-1:0] MIN_CITIES   = COUNT_BITS'(2);
  localparam logic [COUNT_BITS-1:0] CITIES_LIMIT = COUNT_BITS'(MAX_CITIES);

  typedef enum logic [CMD_BITS-1:0] {
    CMD_LOAD   = 2'd0,
    CMD_START  = 2'd1,
    CMD_CHOOSE = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_TARGET,
    ST_SCAN,
    ST_DONE
  } state_t;

  // sequencer to datapath
  typedef struct packed {
    logic                 new_item;
    logic                 pass_start;
    logic                 sum_pass;
    logic                 target_go;
    logic                 rd_vld;
    logic [CITY_BITS-1:0] rd_idx;
  } ctl_t;

  // datapath to sequencer
  typedef struct packed {
    logic                 any;
    logic                 found;
    logic [CITY_BITS-1:0] pick;
  } sts_t;

endpackage

/* rtl/atrs_in_if.sv */
// ----------------------------------------------------------------------------
// atrs_in_if
// command channel: valid/ready handshake with one command word
// ----------------------------------------------------------------------------
interface atrs_in_if;
  logic                             valid;
  logic                             ready;
  logic [atrs_pkg::CMD_BITS-1:0]    command;
  logic [atrs_pkg::CITY_BITS-1:0]   row_city;
  logic [atrs_pkg::CITY_BITS-1:0]   column_city;
  logic [atrs_pkg::WEIGHT_BITS-1:0] weight_value;
  logic [atrs_pkg::CITY_BITS-1:0]   start_city;
  logic [atrs_pkg::RANDOM_BITS-1:0] random_fraction;

  modport source (
    output valid, command, row_city, column_city, weight_value, start_city,
           random_fraction,
    input  ready
  );
  modport sink (
    input  valid, command, row_city, column_city, weight_value, start_city,
           random_fraction,
    output ready
  );
endinterface

/* rtl/atrs_out_if.sv */
// ----------------------------------------------------------------------------
// atrs_out_if
// result channel: valid/ready handshake with one chosen city word
// ----------------------------------------------------------------------------
interface atrs_out_if;
  logic                           valid;
  logic                           ready;
  logic [atrs_pkg::CITY_BITS-1:0] chosen_city;
  logic                           tour_finished;
  logic                           no_candidate;

  modport source (
    output valid, chosen_city, tour_finished, no_candidate,
    input  ready
  );
  modport sink (
    input  valid, chosen_city, tour_finished, no_candidate,
    output ready
  );
endinterface

/* rtl/atrs_weight_ram.sv */
// ----------------------------------------------------------------------------
// atrs_weight_ram
// simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module atrs_weight_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/atrs_roulette.sv */
// ----------------------------------------------------------------------------
// atrs_roulette
// roulette datapath: row sum, target product and running-sum search over the
// weight words streamed out of the table
// ----------------------------------------------------------------------------
module atrs_roulette (
  input  logic                             clk,
  input  logic                             rst_n,
  input  atrs_pkg::ctl_t                   ctl,
  input  logic [atrs_pkg::WEIGHT_BITS-1:0] rd_data,
  input  logic [atrs_pkg::MAX_CITIES-1:0]  visited,
  input  logic [atrs_pkg::RANDOM_BITS-1:0] frac,
  output atrs_pkg::sts_t                   sts
);

  logic [atrs_pkg::MAX_CITIES-1:0] vis_sh_r;
  logic [atrs_pkg::SUM_BITS-1:0]   sum_r;
  logic [atrs_pkg::SUM_BITS-1:0]   run_r;
  logic [atrs_pkg::SUM_BITS-1:0]   target_r;
  logic [atrs_pkg::SUM_BITS-1:0]   run_nxt;
  logic [atrs_pkg::PROD_BITS-1:0]  prod;
  logic                            any_r;
  logic                            found_r;
  logic [atrs_pkg::CITY_BITS-1:0]  first_r;
  logic [atrs_pkg::CITY_BITS-1:0]  pick_r;

  assign run_nxt = run_r + atrs_pkg::SUM_BITS'(rd_data);
  assign prod    = atrs_pkg::PROD_BITS'(sum_r) * atrs_pkg::PROD_BITS'(frac);

  // flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      any_r   <= 1'b0;
      found_r <= 1'b0;
    end else begin
      if (ctl.new_item) begin
        any_r <= 1'b0;
      end else if (ctl.rd_vld && ctl.sum_pass && !vis_sh_r[0]) begin
        any_r <= 1'b1;
      end
      if (ctl.pass_start) begin
        found_r <= 1'b0;
      end else if (ctl.rd_vld && !ctl.sum_pass && !vis_sh_r[0] && !found_r &&
                   rd_data != '0 && run_nxt >= target_r) begin
        found_r <= 1'b1;
      end
    end
  end

  // accumulators and the visited shadow, shifted one city per returned word
  always_ff @(posedge clk) begin
    if (ctl.new_item) begin
      sum_r <= '0;
    end
    if (ctl.pass_start) begin
      vis_sh_r <= visited;
      run_r    <= '0;
    end else if (ctl.rd_vld) begin
      vis_sh_r <= vis_sh_r >> 1;
      if (!vis_sh_r[0]) begin
        if (ctl.sum_pass) begin
          sum_r <= sum_r + atrs_pkg::SUM_BITS'(rd_data);
          if (!any_r) begin
            first_r <= ctl.rd_idx;
          end
        end else if (!found_r && rd_data != '0) begin
          run_r <= run_nxt;
          if (run_nxt >= target_r) begin
            pick_r <= ctl.rd_idx;
          end
        end
      end
    end
    if (ctl.target_go) begin
      target_r <= prod[atrs_pkg::PROD_BITS-1:atrs_pkg::RANDOM_BITS];
    end
  end

  assign sts.any   = any_r;
  assign sts.found = found_r;
  assign sts.pick  = found_r ? pick_r : first_r;

  a_found_reaches_target: assert property (@(posedge clk) disable iff (!rst_n)
    found_r && !ctl.target_go |-> run_r >= target_r)
    else $error("search stopped below the target");

endmodule

/* rtl/ant_tour_roulette_step.sv */
// ----------------------------------------------------------------------------
// ant_tour_roulette_step
// roulette wheel choice of one ant's next city over a loaded weight table
//
//   channel  dir  handshake      word
//   in_ch    in   valid/ready    command, row/column, weight, start, fraction
//   out_ch   out  valid/ready    chosen_city, tour_finished, no_candidate
//   cfg_*    in   write enable   cities_in_use (7 bits)
//
// load and start words are taken in idle and leave the sequencer there. a
// choose word runs two streamed passes over the current row through the
// single read port of the weight ram, each waiting for its last read word
// to land, then the target product step and the commit; no further word is
// taken until the commit returns the sequencer to idle. with no city left
// the search pass is skipped and the commit follows the target step.
// sync reset clears the visited map, current city, sequencer and output
// valid flag; the weight ram is not cleared and must be loaded before use.
// a finished result waits in the output register; load and start words are
// still taken while it waits, a choose stalls only at its commit cycle.
// ----------------------------------------------------------------------------
module ant_tour_roulette_step (
  input  logic                    clk,
  input  logic                    rst_n,
  atrs_in_if.sink                 in_ch,
  atrs_out_if.source              out_ch,
  input  logic                    cfg_we,
  input  logic [atrs_pkg::COUNT_BITS-1:0] cfg_data
);

  atrs_pkg::state_t state_r, state_nxt;

  // block state
  logic [atrs_pkg::COUNT_BITS-1:0]  cities_r;     // effective city count n
  logic [atrs_pkg::MAX_CITIES-1:0]  visited_r, visited_nxt;
  logic [atrs_pkg::CITY_BITS-1:0]   cur_r, cur_nxt;
  logic [atrs_pkg::RANDOM_BITS-1:0] frac_r;

  // read sequencing
  logic [atrs_pkg::COUNT_BITS-1:0]  idx_r, idx_nxt;
  logic                             rd_vld_r;
  logic [atrs_pkg::CITY_BITS-1:0]   rd_idx_r;
  logic                             issue;
  logic [atrs_pkg::WEIGHT_BITS-1:0] rd_data;

  // output register
  logic                             out_valid_r, out_valid_nxt;
  logic [atrs_pkg::CITY_BITS-1:0]   out_city_r, out_city_nxt;
  logic                             out_fin_r, out_fin_nxt;
  logic                             out_none_r, out_none_nxt;

  logic                             accept;
  logic                             is_load, is_start, is_choose;
  logic [atrs_pkg::CITY_BITS-1:0]   start_eff;
  logic [atrs_pkg::MAX_CITIES-1:0]  inuse_mask;
  logic [atrs_pkg::MAX_CITIES-1:0]  pick_bit;
  logic [atrs_pkg::MAX_CITIES-1:0]  visited_pick;
  logic [atrs_pkg::COUNT_BITS-1:0]  cfg_eff;

  atrs_pkg::ctl_t ctl;
  atrs_pkg::sts_t sts;

  assign accept    = in_ch.valid && in_ch.ready;
  assign is_load   = in_ch.command == atrs_pkg::CMD_LOAD;
  assign is_start  = in_ch.command == atrs_pkg::CMD_START;
  assign is_choose = in_ch.command == atrs_pkg::CMD_CHOOSE;

  // start city outside the problem falls back to city zero
  assign start_eff = ({1'b0, in_ch.start_city} < cities_r) ? in_ch.start_city : '0;

  // clamp the configured count into [2, MAX_CITIES]
  always_comb begin
    priority if (cfg_data > atrs_pkg::CITIES_LIMIT) begin
      cfg_eff = atrs_pkg::CITIES_LIMIT;
    end else if (cfg_data < atrs_pkg::MIN_CITIES) begin
      cfg_eff = atrs_pkg::MIN_CITIES;
    end else begin
      cfg_eff = cfg_data;
    end
  end

  always_comb begin
    for (int i = 0; i < atrs_pkg::MAX_CITIES; i++) begin
      inuse_mask[i] = atrs_pkg::COUNT_BITS'(i) < cities_r;
    end
  end

  always_comb begin
    pick_bit           = '0;
    pick_bit[sts.pick] = 1'b1;
  end
  assign visited_pick = visited_r | pick_bit;

  // ---------------------------------------------------------------------------
  // weight table
  // ---------------------------------------------------------------------------
  atrs_weight_ram #(
    .DEPTH (atrs_pkg::TABLE_DEPTH),
    .WIDTH (atrs_pkg::WEIGHT_BITS)
  ) u_wram (
    .clk   (clk),
    .we    (accept && is_load),
    .waddr ({in_ch.row_city, in_ch.column_city}),
    .wdata (in_ch.weight_value),
    .raddr ({cur_r, idx_r[atrs_pkg::CITY_BITS-1:0]}),
    .rdata (rd_data)
  );

  // ---------------------------------------------------------------------------
  // roulette datapath
  // ---------------------------------------------------------------------------
  assign ctl.new_item   = accept && is_choose;
  assign ctl.pass_start = (accept && is_choose) || state_r == atrs_pkg::ST_TARGET;
  assign ctl.sum_pass   = state_r == atrs_pkg::ST_SUM;
  assign ctl.target_go  = state_r == atrs_pkg::ST_TARGET;
  assign ctl.rd_vld     = rd_vld_r;
  assign ctl.rd_idx     = rd_idx_r;

  atrs_roulette u_roulette (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .rd_data (rd_data),
    .visited (visited_r),
    .frac    (frac_r),
    .sts     (sts)
  );

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= atrs_pkg::ST_IDLE;
      cities_r    <= atrs_pkg::CITIES_LIMIT;
      visited_r   <= '0;
      cur_r       <= '0;
      idx_r       <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      visited_r   <= visited_nxt;
      cur_r       <= cur_nxt;
      idx_r       <= idx_nxt;
      rd_vld_r    <= issue;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        cities_r <= cfg_eff;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rd_idx_r   <= idx_r[atrs_pkg::CITY_BITS-1:0];
    out_city_r <= out_city_nxt;
    out_fin_r  <= out_fin_nxt;
    out_none_r <= out_none_nxt;
    if (accept && is_choose) begin
      frac_r <= in_ch.random_fraction;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    visited_nxt   = visited_r;
    cur_nxt       = cur_r;
    idx_nxt       = idx_r;
    issue         = 1'b0;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_city_nxt  = out_city_r;
    out_fin_nxt   = out_fin_r;
    out_none_nxt  = out_none_r;

    unique case (state_r)
      atrs_pkg::ST_IDLE: begin
        if (accept && is_start) begin
          visited_nxt            = '0;
          visited_nxt[start_eff] = 1'b1;
          cur_nxt                = start_eff;
        end
        if (accept && is_choose) begin
          idx_nxt   = '0;
          state_nxt = atrs_pkg::ST_SUM;
        end
      end

      // stream the row out, wait for the last word to land
      atrs_pkg::ST_SUM: begin
        if (idx_r < cities_r) begin
          issue   = 1'b1;
          idx_nxt = idx_r + atrs_pkg::COUNT_BITS'(1);
        end else if (!rd_vld_r) begin
          state_nxt = atrs_pkg::ST_TARGET;
        end
      end

      // target product registers here; nothing left means no search
      atrs_pkg::ST_TARGET: begin
        idx_nxt   = '0;
        state_nxt = sts.any ? atrs_pkg::ST_SCAN : atrs_pkg::ST_DONE;
      end

      // second pass, stops issuing once the running sum hits the target
      atrs_pkg::ST_SCAN: begin
        if (sts.found) begin
          state_nxt = atrs_pkg::ST_DONE;
        end else if (idx_r < cities_r) begin
          issue   = 1'b1;
          idx_nxt = idx_r + atrs_pkg::COUNT_BITS'(1);
        end else if (!rd_vld_r) begin
          state_nxt = atrs_pkg::ST_DONE;
        end
      end

      // commit once the output register is free or being drained
      atrs_pkg::ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          state_nxt     = atrs_pkg::ST_IDLE;
          if (sts.any) begin
            visited_nxt  = visited_pick;
            cur_nxt      = sts.pick;
            out_city_nxt = sts.pick;
            out_fin_nxt  = &(visited_pick | ~inuse_mask);
            out_none_nxt = 1'b0;
          end else begin
            out_city_nxt = cur_r;
            out_fin_nxt  = 1'b1;
            out_none_nxt = 1'b1;
          end
        end
      end

      default: begin
        state_nxt = atrs_pkg::ST_IDLE;
      end
    endcase
  end

  assign in_ch.ready          = state_r == atrs_pkg::ST_IDLE;
  assign out_ch.valid         = out_valid_r;
  assign out_ch.chosen_city   = out_city_r;
  assign out_ch.tour_finished = out_fin_r;
  assign out_ch.no_candidate  = out_none_r;

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  a_pick_unvisited: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == atrs_pkg::ST_DONE && sts.any |-> !visited_r[sts.pick])
    else $error("picked city was already visited");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == atrs_pkg::ST_DONE && out_valid_r && !out_ch.ready
    |=> out_valid_r && $stable(out_city_r) && state_r == atrs_pkg::ST_DONE)
    else $error("pending result word overwritten");

  a_start_one_visited: assert property (@(posedge clk) disable iff (!rst_n)
    accept && is_start |=> $countones(visited_r) == 1)
    else $error("start did not leave exactly one visited city");

endmodule
